// File: hdl/sst_pkg.sv
package sst_pkg;

    // Default sizes of the tracked resource
    localparam int SUBRESOURCES_DEF = 32;
    localparam int STATE_BITS_DEF   = 24;

    // Width of the sub-part index fields on the ports
    localparam int PART_W = 5;

    // Freeze mask after reset
    localparam logic [31:0] FREEZE_RESET = 32'h0000_0EC3;

    // Configuration register indexes
    localparam logic REG_INITIAL = 1'b0;
    localparam logic REG_FREEZE  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic req_load;    // capture the request fields
        logic rd_sub;      // read override at the requested index
        logic rd_walk;     // read override at the walk counter
        logic sub_commit;  // update one override and produce its result
        logic walk_gen;    // produce a move back to the whole state
        logic walk_clear;  // drop the override at the walk counter
        logic whole_gen;   // produce the whole-state change and update it
        logic flush;       // hand the held result to the output as the final one
        logic cnt_clear;   // restart the walk counter
        logic cnt_inc;     // advance the walk counter
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic frozen;        // initial state overlaps the freeze mask
        logic req_whole;     // captured request targets the whole resource
        logic in_range;      // captured sub-part index names a real sub-part
        logic cur_eq_want;   // sub-part already has the desired state
        logic ovr_eq_whole;  // read override equals the whole state
        logic whole_eq_want; // whole state already has the desired state
        logic walk_valid;    // override valid at the walk counter
        logic cnt_last;      // walk counter at the last sub-part
        logic pend_valid;    // a result is held back
        logic gen_ok;        // a new result may be produced this cycle
    } dp_sts_t;

endpackage

// File: hdl/sst_ctrl.sv
module sst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  sst_pkg::dp_sts_t   sts,
    output sst_pkg::ctl_cmd_t  cmd,
    output logic               req_stall
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SUB_CHK  = 3'd2;
    localparam logic [2:0] ST_WALK_RD  = 3'd3;
    localparam logic [2:0] ST_WALK_CHK = 3'd4;
    localparam logic [2:0] ST_WHOLE    = 3'd5;
    localparam logic [2:0] ST_FLUSH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Take a request only while idle
    assign req_stall = (state_reg != ST_IDLE);

    // Sequence the request
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.frozen)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.req_whole)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_WALK_RD;
                end
                else if (!sts.in_range)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_sub = 1'b1;
                    state_next = ST_SUB_CHK;
                end
            end
            ST_SUB_CHK:
            begin
                if (sts.cur_eq_want)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sub_commit = 1'b1;
                    state_next     = ST_FLUSH;
                end
            end
            ST_WALK_RD:
            begin
                if (sts.walk_valid)
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = ST_WALK_CHK;
                end
                else if (sts.cnt_last)
                begin
                    state_next = ST_WHOLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_WALK_CHK:
            begin
                if (sts.ovr_eq_whole || sts.gen_ok)
                begin
                    cmd.walk_gen   = !sts.ovr_eq_whole;
                    cmd.walk_clear = 1'b1;
                    if (sts.cnt_last)
                    begin
                        state_next = ST_WHOLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_WALK_RD;
                    end
                end
            end
            ST_WHOLE:
            begin
                if (sts.whole_eq_want)
                begin
                    state_next = ST_FLUSH;
                end
                else if (sts.gen_ok)
                begin
                    cmd.whole_gen = 1'b1;
                    state_next    = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.gen_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/sst_datapath.sv
module sst_datapath
#(
    parameter int SUBRESOURCES = sst_pkg::SUBRESOURCES_DEF,
    parameter int STATE_BITS   = sst_pkg::STATE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sst_pkg::ctl_cmd_t             cmd,
    output sst_pkg::dp_sts_t              sts,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [STATE_BITS-1:0]         cfg_data,
    input  logic                          action,
    input  logic [sst_pkg::PART_W-1:0]    sub_index,
    input  logic [STATE_BITS-1:0]         desired_state,
    input  logic                          res_stall,
    output logic                          res_valid,
    output logic                          is_whole,
    output logic [sst_pkg::PART_W-1:0]    part_index,
    output logic [STATE_BITS-1:0]         before_state,
    output logic [STATE_BITS-1:0]         after_state,
    output logic                          last
);

    localparam int PW    = sst_pkg::PART_W;
    localparam int IDX_W = (SUBRESOURCES > 1) ? $clog2(SUBRESOURCES) : 1;
    localparam int CMP_W = ((IDX_W > PW) ? IDX_W : PW) + 1;

    // Configuration and whole state
    logic [STATE_BITS-1:0] init_reg;
    logic [STATE_BITS-1:0] freeze_reg;
    logic [STATE_BITS-1:0] whole_reg;

    // Captured request
    logic                  req_action_reg;
    logic [PW-1:0]         req_idx_reg;
    logic [STATE_BITS-1:0] req_want_reg;

    // Overrides
    logic [SUBRESOURCES-1:0] valid_reg;
    logic [STATE_BITS-1:0]   ovr_mem [SUBRESOURCES];
    logic [STATE_BITS-1:0]   rd_data_reg;

    // Walk counter
    logic [IDX_W-1:0] cnt_reg;

    // Held result and output register
    logic                  pend_valid_reg;
    logic                  pend_whole_reg;
    logic [PW-1:0]         pend_idx_reg;
    logic [STATE_BITS-1:0] pend_before_reg;
    logic [STATE_BITS-1:0] pend_after_reg;

    logic                  out_valid_reg;
    logic                  out_whole_reg;
    logic [PW-1:0]         out_idx_reg;
    logic [STATE_BITS-1:0] out_before_reg;
    logic [STATE_BITS-1:0] out_after_reg;
    logic                  out_last_reg;

    logic [IDX_W+PW-1:0]   sub_wide;
    logic [IDX_W+PW-1:0]   cnt_wide;
    logic [IDX_W-1:0]      sub_addr;
    logic [PW-1:0]         cnt_part;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;
    logic [STATE_BITS-1:0] cur_state;
    logic                  gen;
    logic                  out_free;
    logic                  cand_whole;
    logic [PW-1:0]         cand_idx;
    logic [STATE_BITS-1:0] cand_before;
    logic [STATE_BITS-1:0] cand_after;

    // Map between port index width and storage index width
    assign sub_wide = {{IDX_W{1'b0}}, req_idx_reg};
    assign sub_addr = sub_wide[IDX_W-1:0];
    assign cnt_wide = {{PW{1'b0}}, cnt_reg};
    assign cnt_part = cnt_wide[PW-1:0];

    assign rd_en   = cmd.rd_sub | cmd.rd_walk;
    assign rd_addr = cmd.rd_walk ? cnt_reg : sub_addr;

    assign cur_state = valid_reg[sub_addr] ? rd_data_reg : whole_reg;
    assign out_free  = !out_valid_reg || !res_stall;
    assign gen       = cmd.sub_commit | cmd.walk_gen | cmd.whole_gen;

    // Status toward the controller
    always_comb
    begin
        sts               = '0;
        sts.frozen        = |(init_reg & freeze_reg);
        sts.req_whole     = req_action_reg;
        sts.in_range      = (CMP_W'(req_idx_reg) < CMP_W'(SUBRESOURCES));
        sts.cur_eq_want   = (cur_state == req_want_reg);
        sts.ovr_eq_whole  = (rd_data_reg == whole_reg);
        sts.whole_eq_want = (whole_reg == req_want_reg);
        sts.walk_valid    = valid_reg[cnt_reg];
        sts.cnt_last      = (cnt_reg == IDX_W'(SUBRESOURCES - 1));
        sts.pend_valid    = pend_valid_reg;
        sts.gen_ok        = !pend_valid_reg || out_free;
    end

    // Select the result being produced
    always_comb
    begin
        cand_whole  = 1'b0;
        cand_idx    = req_idx_reg;
        cand_before = cur_state;
        cand_after  = req_want_reg;
        if (cmd.walk_gen)
        begin
            cand_idx    = cnt_part;
            cand_before = rd_data_reg;
            cand_after  = whole_reg;
        end
        else if (cmd.whole_gen)
        begin
            cand_whole  = 1'b1;
            cand_idx    = '0;
            cand_before = whole_reg;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_idx_reg  <= sub_index;
            req_want_reg <= desired_state;
        end
    end

    // Override storage with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.sub_commit && (req_want_reg != whole_reg))
        begin
            ovr_mem[sub_addr] <= req_want_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= ovr_mem[rd_addr];
        end
    end

    // Held result payload
    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            pend_whole_reg  <= cand_whole;
            pend_idx_reg    <= cand_idx;
            pend_before_reg <= cand_before;
            pend_after_reg  <= cand_after;
        end
    end

    // Output payload: push the held result when it is replaced or flushed
    always_ff @(posedge clk)
    begin
        if ((gen || cmd.flush) && pend_valid_reg)
        begin
            out_whole_reg  <= pend_whole_reg;
            out_idx_reg    <= pend_idx_reg;
            out_before_reg <= pend_before_reg;
            out_after_reg  <= pend_after_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    // Control state, configuration, whole state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg       <= '0;
            freeze_reg     <= sst_pkg::FREEZE_RESET[STATE_BITS-1:0];
            whole_reg      <= '0;
            req_action_reg <= 1'b0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == sst_pkg::REG_INITIAL))
            begin
                init_reg  <= cfg_data;
                whole_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == sst_pkg::REG_FREEZE))
            begin
                freeze_reg <= cfg_data;
            end
            if (cmd.req_load)
            begin
                req_action_reg <= action;
            end
            if (cmd.whole_gen)
            begin
                whole_reg <= req_want_reg;
            end

            if (cmd.sub_commit)
            begin
                valid_reg[sub_addr] <= (req_want_reg != whole_reg);
            end
            if (cmd.walk_clear)
            begin
                valid_reg[cnt_reg] <= 1'b0;
            end

            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (gen)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((gen || cmd.flush) && pend_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid    = out_valid_reg;
    assign is_whole     = out_whole_reg;
    assign part_index   = out_idx_reg;
    assign before_state = out_before_reg;
    assign after_state  = out_after_reg;
    assign last         = out_last_reg;

endmodule

// File: hdl/subresource_state_tracker.sv
// Resource usage-state tracker: one whole-resource state plus per-sub-part overrides.
// Request channel (req_valid / req_stall): action, sub_index, desired_state. A
// transfer takes place when req_valid is high and req_stall is low; req_stall is
// high from the cycle after a transfer until the request is fully finished.
// Result channel (res_valid / res_stall): is_whole, part_index, before_state,
// after_state, last. A request yields zero or more results; last marks its final one.
// Configuration: cfg_we with cfg_index 0 writes initial_state (also reloads the
// whole state), index 1 writes freeze_mask. Write only while the block is idle.
// Sequence: a sub-part request is dispatched, checked against its current state and,
// when it changes, committed and handed off as a result; a frozen or out-of-range
// request ends at dispatch. A whole request walks every sub-part through the shared
// override memory, moving each differing override back to the whole state, then
// updates the whole state and hands off the final result before returning to idle.
// Results leave through a one-deep hold stage and an output register; while the
// receiver stalls, the output holds and the walk pauses at the next result.
// Reset clears all overrides, loads whole state and initial_state with zero and
// the freeze mask with its default; the block leaves reset idle and ready for a request.
module subresource_state_tracker
#(
    parameter int SUBRESOURCES = sst_pkg::SUBRESOURCES_DEF,
    parameter int STATE_BITS   = sst_pkg::STATE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [STATE_BITS-1:0]         cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          action,
    input  logic [sst_pkg::PART_W-1:0]    sub_index,
    input  logic [STATE_BITS-1:0]         desired_state,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          is_whole,
    output logic [sst_pkg::PART_W-1:0]    part_index,
    output logic [STATE_BITS-1:0]         before_state,
    output logic [STATE_BITS-1:0]         after_state,
    output logic                          last
);

    sst_pkg::ctl_cmd_t cmd;
    sst_pkg::dp_sts_t  sts;

    sst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    sst_datapath
    #(
        .SUBRESOURCES (SUBRESOURCES),
        .STATE_BITS   (STATE_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .sub_index     (sub_index),
        .desired_state (desired_state),
        .res_stall     (res_stall),
        .res_valid     (res_valid),
        .is_whole      (is_whole),
        .part_index    (part_index),
        .before_state  (before_state),
        .after_state   (after_state),
        .last          (last)
    );

    // Nothing is held back while the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !sts.pend_valid)
        else $error("held result while idle");

    // At most one result action per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.sub_commit, cmd.walk_gen, cmd.whole_gen, cmd.flush}))
        else $error("conflicting result commands");

    // A push into the output never overwrites a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.sub_commit || cmd.walk_gen || cmd.whole_gen || cmd.flush)
            && sts.pend_valid) |-> (!res_valid || !res_stall))
        else $error("output overwritten while stalled");

    // A final result ends the request: the block is idle right after it is pushed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !req_stall)
        else $error("block busy after final result");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int NSUB = sst_pkg::SUBRESOURCES_DEF;
    localparam int SW   = sst_pkg::STATE_BITS_DEF;
    localparam int PW   = sst_pkg::PART_W;

    // Request codes on the action field
    localparam logic ACT_SUB   = 1'b0;
    localparam logic ACT_WHOLE = 1'b1;

    // Longest whole walk with every override set, plus margin
    localparam int SETTLE_CYCLES  = 2 * NSUB + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic          act;
        logic [PW-1:0] idx;
        logic [SW-1:0] want;
        logic          drain;
    } request_t;

    typedef struct {
        logic          whole;
        logic [PW-1:0] part;
        logic [SW-1:0] before_st;
        logic [SW-1:0] after_st;
        logic          last;
    } transition_t;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          cfg_we        = 1'b0;
    logic          cfg_index     = sst_pkg::REG_INITIAL;
    logic [SW-1:0] cfg_data      = '0;
    logic          req_valid     = 1'b0;
    logic          req_stall;
    logic          action        = ACT_SUB;
    logic [PW-1:0] sub_index     = '0;
    logic [SW-1:0] desired_state = '0;
    logic          res_valid;
    logic          res_stall     = 1'b0;
    logic          is_whole;
    logic [PW-1:0] part_index;
    logic [SW-1:0] before_state;
    logic [SW-1:0] after_state;
    logic          last;

    // Tracker copy used to predict transitions
    logic [SW-1:0] init_reg;
    logic [SW-1:0] freeze_reg;
    logic [SW-1:0] whole_st;
    logic          ovr_valid [NSUB];
    logic [SW-1:0] ovr_state [NSUB];

    request_t    request_fifo[$];
    transition_t due_transitions[$];
    int          queued        = 0;
    int          mismatch_cnt  = 0;
    int          quiet_cycles  = 0;
    int          send_gap      = 0;
    int          stall_run     = 0;
    bit          send_calm     = 1'b0;
    bit          recv_calm     = 1'b0;
    logic        req_taken     = 1'b0;

    subresource_state_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .action        (action),
        .sub_index     (sub_index),
        .desired_state (desired_state),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .is_whole      (is_whole),
        .part_index    (part_index),
        .before_state  (before_state),
        .after_state   (after_state),
        .last          (last)
    );

    always #6 clk = ~clk;

    // Predict the transitions of one accepted request and update the copy
    task automatic track_request(input logic act, input logic [PW-1:0] idx,
                                 input logic [SW-1:0] want);
        logic [SW-1:0] cur;
        int            mark;
        mark = due_transitions.size();
        if ((init_reg & freeze_reg) != '0)
            return;
        if (act == ACT_SUB) begin
            if (int'(idx) >= NSUB)
                return;
            cur = ovr_valid[idx] ? ovr_state[idx] : whole_st;
            if (cur == want)
                return;
            if (want == whole_st) begin
                ovr_valid[idx] = 1'b0;
            end
            else begin
                ovr_valid[idx] = 1'b1;
                ovr_state[idx] = want;
            end
            due_transitions.push_back('{1'b0, idx, cur, want, 1'b0});
        end
        else begin
            // Move every override back to the whole state, lowest index first
            for (int i = 0; i < NSUB; i++) begin
                if (ovr_valid[i]) begin
                    if (ovr_state[i] != whole_st)
                        due_transitions.push_back('{1'b0, PW'(i), ovr_state[i], whole_st, 1'b0});
                    ovr_valid[i] = 1'b0;
                end
            end
            if (whole_st != want) begin
                due_transitions.push_back('{1'b1, '0, whole_st, want, 1'b0});
                whole_st = want;
            end
        end
        if (due_transitions.size() > mark)
            due_transitions[due_transitions.size() - 1].last = 1'b1;
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Desired state: a small pool so that equal states recur, else fully random
    function automatic logic [SW-1:0] pick_state();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SW'(24'h000030);
            3:       return SW'(24'h800000);
            4:       return SW'(1) << $urandom_range(0, SW - 1);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic queue_request(input logic act, input logic [PW-1:0] idx,
                                 input logic [SW-1:0] want, input logic drain);
        request_fifo.push_back('{act, idx, want, drain});
        queued++;
    endtask

    // A run of sub-part changes closed by a whole change
    task automatic queue_burst();
        int n;
        int span;
        n = $urandom_range(1, 6);
        span = ($urandom_range(0, 1) != 0) ? 3 : NSUB - 1;
        repeat (n)
            queue_request(ACT_SUB, PW'($urandom_range(0, span)), pick_state(), 1'b0);
        queue_request(ACT_WHOLE, PW'($urandom), pick_state(), 1'b0);
    endtask

    // Set an override on every sub-part, then walk them all back
    task automatic queue_full_walk(input logic drain);
        int rot;
        rot = $urandom_range(0, NSUB - 1);
        for (int i = 0; i < NSUB; i++)
            queue_request(ACT_SUB, PW'((i + rot) % NSUB),
                          SW'($urandom) | SW'(24'h100000), (i == 0) ? drain : 1'b0);
        queue_request(ACT_WHOLE, PW'($urandom), pick_state(), 1'b0);
    endtask

    // Mostly well-formed bursts, the rest single random requests
    task automatic queue_random(input int count);
        int start;
        start = queued;
        while (queued - start < count) begin
            if ($urandom_range(0, 4) != 0)
                queue_burst();
            else
                queue_request(logic'($urandom), PW'($urandom), SW'($urandom), 1'b0);
        end
    endtask

    // Wait for the block to drain, then let any result-free request finish
    task automatic wait_idle();
        while (request_fifo.size() != 0 || req_valid || req_stall || due_transitions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [SW-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == sst_pkg::REG_INITIAL) begin
            init_reg = value;
            whole_st = value;
        end
        else begin
            freeze_reg = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request driver: present the next pending request after a random gap
    always @(negedge clk) begin
        request_t item;
        if (rst_n) begin
            if (req_valid && !req_taken) begin
                // hold the payload until the transfer
            end
            else if (send_gap > 0) begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (request_fifo.size() != 0 &&
                     !(request_fifo[0].drain && due_transitions.size() != 0)) begin
                item = request_fifo.pop_front();
                action        <= item.act;
                sub_index     <= item.idx;
                desired_state <= item.want;
                req_valid     <= 1'b1;
                if ($urandom_range(0, 29) == 0)
                    send_calm = !send_calm;
                send_gap = idle_len(send_calm);
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result stall: alternate open and stalled runs of random length
    always @(negedge clk) begin
        if (stall_run > 0) begin
            stall_run--;
        end
        else if (res_stall || recv_calm || $urandom_range(0, 2) != 0) begin
            res_stall <= 1'b0;
            stall_run = recv_calm ? 40 : $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0)
                recv_calm = !recv_calm;
        end
        else begin
            res_stall <= 1'b1;
            stall_run = idle_len(1'b0);
        end
    end

    // Monitor: check results, predict accepted requests, watch for a hang
    always @(posedge clk) begin
        transition_t exp_t;
        logic        req_xfer;
        logic        res_xfer;
        req_xfer = rst_n && req_valid && !req_stall;
        res_xfer = rst_n && res_valid && !res_stall;
        req_taken <= req_xfer;
        if (res_xfer) begin
            if (due_transitions.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t unexpected result: whole=%0b part=%0d %h->%h last=%0b",
                             $realtime, is_whole, part_index, before_state, after_state, last);
            end
            else begin
                exp_t = due_transitions.pop_front();
                if (is_whole !== exp_t.whole || part_index !== exp_t.part ||
                    before_state !== exp_t.before_st || after_state !== exp_t.after_st ||
                    last !== exp_t.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"%0t result differs: expected whole=%0b part=%0d ",
                                  "%h->%h last=%0b, got whole=%0b part=%0d %h->%h last=%0b"},
                                 $realtime, exp_t.whole, exp_t.part, exp_t.before_st,
                                 exp_t.after_st, exp_t.last, is_whole, part_index,
                                 before_state, after_state, last);
                end
            end
        end
        if (req_xfer)
            track_request(action, sub_index, desired_state);
        if (rst_n) begin
            if (req_xfer || res_xfer)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        init_reg   = '0;
        freeze_reg = SW'(sst_pkg::FREEZE_RESET);
        whole_st   = '0;
        for (int i = 0; i < NSUB; i++) begin
            ovr_valid[i] = 1'b0;
            ovr_state[i] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, no-change, clearing, walks with and without a whole change
        queue_request(ACT_SUB,   5'd0,  24'hFFFFFF, 1'b0);
        queue_request(ACT_SUB,   5'd31, 24'h800001, 1'b0);
        queue_request(ACT_SUB,   5'd31, 24'h800001, 1'b0);
        queue_request(ACT_SUB,   5'd0,  24'h000000, 1'b0);
        queue_request(ACT_SUB,   5'd5,  24'h000030, 1'b0);
        queue_request(ACT_SUB,   5'd7,  24'h000000, 1'b0);
        queue_request(ACT_WHOLE, 5'd31, 24'h000FF0, 1'b0);
        queue_request(ACT_WHOLE, 5'd0,  24'h000FF0, 1'b0);
        queue_request(ACT_SUB,   5'd12, 24'hAAAAAA, 1'b0);
        queue_request(ACT_SUB,   5'd12, 24'h555555, 1'b0);
        queue_request(ACT_SUB,   5'd12, 24'h000FF0, 1'b0);
        queue_request(ACT_WHOLE, 5'd0,  24'h000000, 1'b0);
        queue_request(ACT_SUB,   5'd3,  24'h000FF0, 1'b0);
        queue_request(ACT_WHOLE, 5'd0,  24'h000000, 1'b0);
        queue_request(ACT_SUB,   5'd31, 24'hFFFFFF, 1'b0);
        queue_request(ACT_SUB,   5'd0,  24'h000001, 1'b0);
        queue_request(ACT_WHOLE, 5'd21, 24'hFFFFFF, 1'b0);

        // Default configuration; hold off the full walk until all results are in
        queue_random(40);
        queue_full_walk(1'b1);
        queue_random(40);
        // Leave overrides that will equal the reloaded whole state
        queue_request(ACT_SUB, 5'd9,  24'h000030, 1'b0);
        queue_request(ACT_SUB, 5'd10, 24'h000030, 1'b0);
        wait_idle();

        // Reload the whole state while overrides stay in place
        cfg_write(sst_pkg::REG_INITIAL, 24'h000030);
        queue_request(ACT_WHOLE, 5'd0, 24'h000030, 1'b0);
        queue_random(60);
        wait_idle();

        // No freeze, all-ones whole state
        cfg_write(sst_pkg::REG_FREEZE, 24'h000000);
        cfg_write(sst_pkg::REG_INITIAL, 24'hFFFFFF);
        queue_random(50);
        wait_idle();

        // Frozen: nothing may come out
        cfg_write(sst_pkg::REG_FREEZE, 24'hFFFFFF);
        queue_random(20);
        wait_idle();

        // Full freeze mask but zero initial state: active again
        cfg_write(sst_pkg::REG_INITIAL, 24'h000000);
        queue_full_walk(1'b0);
        queue_random(40);
        wait_idle();

        if (due_transitions.size() != 0)
            $display("%0d expected results never arrived", due_transitions.size());
        if (mismatch_cnt == 0 && due_transitions.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
